// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the glob matcher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define GWM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside of reset.
`define GWM_NEVER(label, cond, msg) \
   `GWM_ASSERT(label, !(cond), msg)

`endif

// ----- hdl/gwm_pkg.sv -----
// Shared types, constants and helpers of the glob wildcard matcher.
package gwm_pkg;

   localparam int PAT_SLOTS = 16;
   localparam int LEN_W     = 5;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 64;

   localparam logic [7:0] STAR_CODE  = 8'h2A;
   localparam logic [7:0] QMARK_CODE = 8'h3F;
   localparam logic [7:0] UPPER_A    = 8'h41;
   localparam logic [7:0] UPPER_Z    = 8'h5A;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   typedef enum logic [1:0] {
      CSR_PAT_LOW  = 2'd0,
      CSR_PAT_HIGH = 2'd1,
      CSR_PAT_LEN  = 2'd2,
      CSR_CASE     = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [7:0] name_byte;
      logic       name_last;
   } q_item_type;

   typedef struct packed {
      logic [PAT_SLOTS-1:0][7:0] bytes;
      logic [PAT_SLOTS-1:0]      star;
      logic [PAT_SLOTS-1:0]      qmark;
      logic [LEN_W-1:0]          len;
      logic                      has_wild;
      logic                      fold_en;
      logic                      restart;
   } pat_info_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
      logic [7:0] r;
      r = c;
      if (fold_en && c >= UPPER_A && c <= UPPER_Z) begin
         r = c + CASE_DELTA;
      end
      return r;
   endfunction

endpackage

// ----- hdl/gwm_csr.sv -----
// Configuration registers and decoded pattern information.
module gwm_csr
   import gwm_pkg::*;
#(
   parameter int PATTERN_MAX = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output pat_info_type      info
);
`include "assert_macros.svh"

   localparam logic [LEN_W-1:0] PatLen = LEN_W'(PATTERN_MAX);

   logic [63:0]      pat_low_ff, pat_low_in;
   logic [63:0]      pat_high_ff, pat_high_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             case_ff, case_in;
   logic             wr_en;
   csr_reg_type      reg_sel;
   logic [LEN_W-1:0] used_len;
   logic [7:0]       folded;
   logic             any_wild;
   logic             len_oversize;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_reg_type'(csr_paddr[4:3]);

   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      len_in      = len_ff;
      case_in     = case_ff;
      if (wr_en) begin
         unique case (reg_sel)
            CSR_PAT_LOW:  pat_low_in  = csr_pwdata[63:0];
            CSR_PAT_HIGH: pat_high_in = csr_pwdata[63:0];
            CSR_PAT_LEN:  len_in      = csr_pwdata[LEN_W-1:0];
            CSR_CASE:     case_in     = csr_pwdata[0];
            default:      len_in      = len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         len_ff      <= '0;
         case_ff     <= 1'b0;
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         len_ff      <= len_in;
         case_ff     <= case_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         CSR_PAT_LOW:  csr_prdata = pat_low_ff;
         CSR_PAT_HIGH: csr_prdata = pat_high_ff;
         CSR_PAT_LEN:  csr_prdata = {{(CSR_DW-LEN_W){1'b0}}, len_ff};
         CSR_CASE:     csr_prdata = {{(CSR_DW-1){1'b0}}, case_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // Clamp an oversized length to the supported pattern size.
   assign used_len = (len_ff > PatLen) ? PatLen : len_ff;

   always_comb begin
      any_wild = 1'b0;
      folded   = '0;
      for (int j = 0; j < PAT_SLOTS; j++) begin
         if (j < 8) begin
            folded = fold_byte(pat_low_ff[8*(j%8) +: 8], ~case_ff);
         end else begin
            folded = fold_byte(pat_high_ff[8*(j%8) +: 8], ~case_ff);
         end
         info.bytes[j] = folded;
         info.star[j]  = (folded == STAR_CODE);
         info.qmark[j] = (folded == QMARK_CODE);
         if (LEN_W'(j) < used_len && (folded == STAR_CODE || folded == QMARK_CODE)) begin
            any_wild = 1'b1;
         end
      end
      info.len      = used_len;
      info.has_wild = any_wild;
      info.fold_en  = ~case_ff;
      info.restart  = wr_en;
   end

   assign len_oversize = wr_en && reg_sel == CSR_PAT_LEN && (csr_pwdata[LEN_W-1:0] > PatLen);

   `GWM_ASSERT(a_len_clamp, len_oversize |=> (info.len == PatLen), "length not clamped")

endmodule

// ----- hdl/gwm_front.sv -----
// Front end: accepts name bytes, folds case and queues them for the matcher.
module gwm_front
   import gwm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tlast,
   input  logic         fold_en,
   output logic         q_valid,
   output q_item_type   q_head,
   input  logic         q_pop
);
`include "assert_macros.svh"

   q_item_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push;
   q_item_type incoming;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid & req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_head     = slot_ff[rd_ptr_ff];

   always_comb begin
      incoming.name_byte = fold_byte(req_tdata, fold_en);
      incoming.name_last = req_tlast;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   `GWM_NEVER(a_no_overfill, count_ff == 2'd3, "queue count beyond depth")
   `GWM_NEVER(a_no_empty_pop, q_pop && count_ff == 2'd0, "pop from empty queue")

endmodule

// ----- hdl/gwm_back.sv -----
// Back end: advances the active position set and registers the match result.
module gwm_back
   import gwm_pkg::*;
#(
   parameter int PATTERN_MAX = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  pat_info_type info,
   input  logic         q_valid,
   input  q_item_type   q_head,
   output logic         q_pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         matched
);
`include "assert_macros.svh"

   localparam int SetW = PATTERN_MAX + 1;

   logic [SetW-1:0]        set_ff, set_in;
   logic                   start_ff, start_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   matched_ff, matched_in;
   logic [PATTERN_MAX-1:0] len_mask;
   logic [PATTERN_MAX-1:0] star;
   logic [PATTERN_MAX-1:0] step_ok;
   logic [SetW-1:0]        end_mask;
   logic [SetW-1:0]        start_set;
   logic [SetW-1:0]        old_set;
   logic [SetW-1:0]        raw_next;
   logic [SetW-1:0]        next_set;
   logic                   hit;
   logic                   pop_last;

   // Spread set bits upward through runs of '*': the carries of star + (set & star)
   // are exactly the positions reached through a star.
   function automatic logic [SetW-1:0] close_run(input logic [SetW-1:0] s,
                                                 input logic [PATTERN_MAX-1:0] t);
      logic [SetW-1:0] a;
      logic [SetW-1:0] b;
      logic [SetW-1:0] sum;
      a   = {1'b0, t};
      b   = {1'b0, s[PATTERN_MAX-1:0] & t};
      sum = a + b;
      return s | (sum ^ a ^ b);
   endfunction

   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         len_mask[j] = (LEN_W'(j) < info.len);
         step_ok[j]  = info.qmark[j] | (info.bytes[j] == q_head.name_byte);
      end
      for (int k = 0; k < SetW; k++) begin
         end_mask[k] = (LEN_W'(k) == info.len);
      end
   end

   assign star      = info.star[PATTERN_MAX-1:0] & len_mask;
   assign start_set = close_run(SetW'(1), star);
   assign old_set   = start_ff ? start_set : set_ff;

   always_comb begin
      raw_next = {old_set[PATTERN_MAX-1:0] & ~star & step_ok & len_mask, 1'b0}
               | {1'b0, old_set[PATTERN_MAX-1:0] & star};
      // Without wildcards the pattern floats: implicit leading and trailing star.
      if (!info.has_wild) begin
         raw_next = raw_next | (old_set & end_mask) | SetW'(1);
      end
      next_set = close_run(raw_next, star);
      hit      = (info.len == '0) ? 1'b1 : |(next_set & end_mask);
   end

   assign q_pop    = q_valid & (~rsp_valid_ff | rsp_tready);
   assign pop_last = q_pop & q_head.name_last;

   always_comb begin
      set_in       = set_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      matched_in   = matched_ff;
      if (info.restart) begin
         start_in = 1'b1;
      end else if (q_pop) begin
         if (q_head.name_last) begin
            start_in     = 1'b1;
            rsp_valid_in = 1'b1;
            matched_in   = hit;
         end else begin
            start_in = 1'b0;
            set_in   = next_set;
         end
      end
   end

   always_ff @(posedge clock) begin
      set_ff     <= set_in;
      matched_ff <= matched_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign matched    = matched_ff;

   `GWM_ASSERT(a_rsp_from_last, $rose(rsp_valid_ff) |-> $past(pop_last), "result without last byte")
   `GWM_ASSERT(a_restart_after_last, pop_last |=> start_ff, "set not back to start after a name")

endmodule

// ----- hdl/glob_wildcard_matcher_top.sv -----
// A name's result is registered in the back end once its last byte is popped from the queue.
// Throughput: one name byte per cycle while the queue is not full; the back end updates
// the position set with one add-based star closure per byte, and a two-entry queue decouples it.
// A result held by rsp_tready stalls the back end; the queue then fills up to its two entries.
// Reset (synchronous, active high) clears the pattern registers to zero, empties
// the queue and returns the position set to the start set of the empty pattern.
module glob_wildcard_matcher_top
   import gwm_pkg::*;
#(
   parameter int PATTERN_MAX = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,    // [7:0] name_byte
   input  logic              req_tlast,    // name_last
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,    // [0] matched, [7:1] zero
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   pat_info_type info;
   q_item_type   q_head;
   logic         q_valid;
   logic         q_pop;
   logic         matched;

   gwm_csr #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .info        (info)
   );

   gwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .fold_en    (info.fold_en),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   gwm_back #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .info       (info),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .matched    (matched)
   );

   assign rsp_tdata = {7'b0, matched};

endmodule
